// ===== hw/rtl/pixel_mask_overlap_test_macros.svh =====
// Assertion macros for the checker of the overlap test block.
`ifndef PIXEL_MASK_OVERLAP_TEST_MACROS_SVH
`define PIXEL_MASK_OVERLAP_TEST_MACROS_SVH

// Same-cycle implication, off during reset.
`define PMOT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmot assertion failed");

// Next-cycle implication, off during reset.
`define PMOT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pmot assertion failed");

// Next-cycle implication that also holds across reset.
`define PMOT_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pmot reset assertion failed");

`endif

// ===== hw/rtl/pmot_pkg.sv =====
`timescale 1ns / 1ps
package pmot_pkg;

  localparam int MAX_DIM    = 64;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int CRD_W      = 14;
  localparam int POS_W      = 12;
  localparam int SIZE_W     = 7;
  localparam int PIX_W      = 6;
  localparam int ALPHA_W    = 8;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_A_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_BOTTOM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_B_HEIGHT = 3'd7;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef logic [MAX_DIM-1:0] row_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    row_t             wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/pmot_if.sv =====
`timescale 1ns / 1ps
interface pmot_req_if;
  logic                         valid;
  logic                         ready;
  logic [pmot_pkg::REQ_W-1:0]   req_type;
  logic [pmot_pkg::PIX_W-1:0]   pix_x;
  logic [pmot_pkg::PIX_W-1:0]   pix_y;
  logic [pmot_pkg::ALPHA_W-1:0] alpha;
  modport source (output valid, req_type, pix_x, pix_y, alpha, input ready);
  modport sink (input valid, req_type, pix_x, pix_y, alpha, output ready);
endinterface

interface pmot_rsp_if;
  logic valid;
  logic ready;
  logic hit;
  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

interface pmot_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pmot_pkg::CFG_IDX_W-1:0]  index;
  logic [pmot_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/pmot_mask_mem.sv =====
`timescale 1ns / 1ps
module pmot_mask_mem (
  input  logic               clk,
  input  logic               rst,
  input  pmot_pkg::mem_req_t req,
  output pmot_pkg::row_t     rd_data
);

  pmot_pkg::row_t                 mem [pmot_pkg::MAX_DIM];
  logic [pmot_pkg::MAX_DIM-1:0]   row_vld;
  pmot_pkg::row_t                 rd_q;
  logic                           rd_v;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
      rd_v <= row_vld[req.rd_addr];
    end
  end

  // a row never written reads as transparent
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (req.wr_en) begin
      row_vld[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_v ? rd_q : '0;

endmodule

// ===== hw/rtl/pixel_mask_overlap_test.sv =====
`timescale 1ns / 1ps
// Pixel load: row read, then row write back; the next request waits for the write.
// Test: BOX, PREP, SCAN (one step per overlap row), DRAIN, FIN; the scan
//   reads one mask row word from each memory per cycle.
// Disjoint or empty boxes: PREP goes straight to FIN, skipping the scan.
// Reset (synchronous): masks read as all transparent, positions 0, sizes 64.
module pixel_mask_overlap_test (
  input  logic       clk,
  input  logic       rst,
  pmot_req_if.sink   req,
  pmot_rsp_if.source rsp,
  pmot_cfg_if.sink   cfg
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_BOX   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  logic signed [pmot_pkg::POS_W-1:0] a_left, a_bottom, b_left, b_bottom;
  logic [pmot_pkg::SIZE_W-1:0]       a_width, a_height, b_width, b_height;

  logic signed [pmot_pkg::CRD_W-1:0] al, ab, bl, bb;
  logic signed [pmot_pkg::CRD_W-1:0] aw, ah, bw, bh;
  logic signed [pmot_pkg::CRD_W-1:0] ax1, ay1, bx1, by1;
  logic signed [pmot_pkg::CRD_W-1:0] x0, x1, y0, y1;
  logic signed [pmot_pkg::CRD_W-1:0] x0_next, x1_next, y0_next, y1_next;

  logic [pmot_pkg::IDX_W-1:0] xoff_a, xoff_b, row_a, row_b;
  logic [pmot_pkg::CNT_W-1:0] xcnt, rows;

  logic                       ld_sel;
  logic                       ld_bit;
  logic [pmot_pkg::IDX_W-1:0] ld_x, ld_y;
  logic [pmot_pkg::IDX_W-1:0] px_i, py_i;

  logic acc, acc_load, acc_test, in_range;
  logic rd_pend, hit_acc, row_hit, box_empty;
  logic out_valid, out_hit, out_load;

  pmot_pkg::mem_req_t mreq_a, mreq_b;
  pmot_pkg::row_t     rd_a, rd_b, base_row, new_row, sh_a, sh_b, col_mask;

  assign acc      = req.valid && req.ready;
  assign px_i     = pmot_pkg::IDX_W'(req.pix_x);
  assign py_i     = pmot_pkg::IDX_W'(req.pix_y);
  assign in_range = (int'(req.pix_x) < pmot_pkg::MAX_DIM) &&
                    (int'(req.pix_y) < pmot_pkg::MAX_DIM);
  assign acc_load = acc && in_range &&
                    (req.req_type == pmot_pkg::REQ_LOAD_A ||
                     req.req_type == pmot_pkg::REQ_LOAD_B);
  assign acc_test = acc && (req.req_type == pmot_pkg::REQ_TEST);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_left   <= '0;
      a_bottom <= '0;
      a_width  <= pmot_pkg::SIZE_RESET;
      a_height <= pmot_pkg::SIZE_RESET;
      b_left   <= '0;
      b_bottom <= '0;
      b_width  <= pmot_pkg::SIZE_RESET;
      b_height <= pmot_pkg::SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pmot_pkg::REG_A_LEFT:   a_left   <= cfg.data;
        pmot_pkg::REG_A_BOTTOM: a_bottom <= cfg.data;
        pmot_pkg::REG_A_WIDTH:  a_width  <= cfg.data[pmot_pkg::SIZE_W-1:0];
        pmot_pkg::REG_A_HEIGHT: a_height <= cfg.data[pmot_pkg::SIZE_W-1:0];
        pmot_pkg::REG_B_LEFT:   b_left   <= cfg.data;
        pmot_pkg::REG_B_BOTTOM: b_bottom <= cfg.data;
        pmot_pkg::REG_B_WIDTH:  b_width  <= cfg.data[pmot_pkg::SIZE_W-1:0];
        pmot_pkg::REG_B_HEIGHT: b_height <= cfg.data[pmot_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // box geometry, sizes clamped to the mask dimension
  always_comb begin
    al = pmot_pkg::CRD_W'(a_left);
    ab = pmot_pkg::CRD_W'(a_bottom);
    bl = pmot_pkg::CRD_W'(b_left);
    bb = pmot_pkg::CRD_W'(b_bottom);
    aw = (int'(a_width) > pmot_pkg::MAX_DIM) ? pmot_pkg::CRD_W'(pmot_pkg::MAX_DIM)
                                             : pmot_pkg::CRD_W'(a_width);
    ah = (int'(a_height) > pmot_pkg::MAX_DIM) ? pmot_pkg::CRD_W'(pmot_pkg::MAX_DIM)
                                              : pmot_pkg::CRD_W'(a_height);
    bw = (int'(b_width) > pmot_pkg::MAX_DIM) ? pmot_pkg::CRD_W'(pmot_pkg::MAX_DIM)
                                             : pmot_pkg::CRD_W'(b_width);
    bh = (int'(b_height) > pmot_pkg::MAX_DIM) ? pmot_pkg::CRD_W'(pmot_pkg::MAX_DIM)
                                              : pmot_pkg::CRD_W'(b_height);
    ax1 = al + aw;
    ay1 = ab + ah;
    bx1 = bl + bw;
    by1 = bb + bh;
    x0_next = (al > bl) ? al : bl;
    y0_next = (ab > bb) ? ab : bb;
    x1_next = (ax1 < bx1) ? ax1 : bx1;
    y1_next = (ay1 < by1) ? ay1 : by1;
  end

  assign box_empty = (x0 >= x1) || (y0 >= y1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc_load) begin
          state_next = S_LOAD;
        end else if (acc_test) begin
          state_next = S_BOX;
        end
      end
      S_LOAD: state_next = S_IDLE;
      S_BOX:  state_next = S_PREP;
      S_PREP: state_next = box_empty ? S_FIN : S_SCAN;
      S_SCAN: begin
        if (rows == pmot_pkg::CNT_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // load: hold the pixel while its row is read
  always_ff @(posedge clk) begin
    if (acc_load) begin
      ld_sel <= (req.req_type == pmot_pkg::REQ_LOAD_B);
      ld_bit <= (req.alpha != '0);
      ld_x   <= px_i;
      ld_y   <= py_i;
    end
  end

  always_comb begin
    base_row = ld_sel ? rd_b : rd_a;
    new_row  = base_row;
    new_row[ld_x] = ld_bit;
  end

  always_comb begin
    mreq_a.rd_en   = acc_load || (state == S_SCAN);
    mreq_a.rd_addr = (state == S_SCAN) ? row_a : py_i;
    mreq_a.wr_en   = (state == S_LOAD) && !ld_sel;
    mreq_a.wr_addr = ld_y;
    mreq_a.wr_data = new_row;
    mreq_b.rd_en   = acc_load || (state == S_SCAN);
    mreq_b.rd_addr = (state == S_SCAN) ? row_b : py_i;
    mreq_b.wr_en   = (state == S_LOAD) && ld_sel;
    mreq_b.wr_addr = ld_y;
    mreq_b.wr_data = new_row;
  end

  pmot_mask_mem u_mask_a (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq_a),
    .rd_data (rd_a)
  );

  pmot_mask_mem u_mask_b (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq_b),
    .rd_data (rd_b)
  );

  // scan setup and row walk
  always_ff @(posedge clk) begin
    if (state == S_BOX) begin
      x0 <= x0_next;
      x1 <= x1_next;
      y0 <= y0_next;
      y1 <= y1_next;
    end
    if (state == S_PREP) begin
      xoff_a <= pmot_pkg::IDX_W'(x0 - al);
      xoff_b <= pmot_pkg::IDX_W'(x0 - bl);
      xcnt   <= pmot_pkg::CNT_W'(x1 - x0);
      row_a  <= pmot_pkg::IDX_W'(y0 - ab);
      row_b  <= pmot_pkg::IDX_W'(y0 - bb);
      rows   <= pmot_pkg::CNT_W'(y1 - y0);
    end else if (state == S_SCAN) begin
      row_a <= row_a + pmot_pkg::IDX_W'(1);
      row_b <= row_b + pmot_pkg::IDX_W'(1);
      rows  <= rows - pmot_pkg::CNT_W'(1);
    end
  end

  // align both rows to the overlap's left column, keep its width
  assign sh_a     = rd_a >> xoff_a;
  assign sh_b     = rd_b >> xoff_b;
  assign col_mask = {pmot_pkg::MAX_DIM{1'b1}} >>
                    (pmot_pkg::CNT_W'(pmot_pkg::MAX_DIM) - xcnt);
  assign row_hit  = |(sh_a & sh_b & col_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PREP) begin
      hit_acc <= 1'b0;
    end else if (rd_pend) begin
      hit_acc <= hit_acc | row_hit;
    end
  end

  // output word register
  assign out_load = (state == S_FIN) && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit <= hit_acc;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.hit   = out_hit;

endmodule

// ===== hw/rtl/pmot_checker.sv =====
`timescale 1ns / 1ps
`include "pixel_mask_overlap_test_macros.svh"
module pmot_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [pmot_pkg::REQ_W-1:0] req_type,
  input logic                       rsp_valid,
  input logic                       rsp_ready
);

  logic [1:0] tests_open;
  logic       test_acc;
  logic       rsp_acc;

  assign test_acc = req_valid && req_ready && (req_type == pmot_pkg::REQ_TEST);
  assign rsp_acc  = rsp_valid && rsp_ready;

  // track tests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      tests_open <= 2'd0;
    end else begin
      unique case ({test_acc, rsp_acc})
        2'b10:   tests_open <= tests_open + 2'd1;
        2'b01:   tests_open <= tests_open - 2'd1;
        default: tests_open <= tests_open;
      endcase
    end
  end

  `PMOT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  `PMOT_ASSERT_IMPL(a_rsp_has_test, rsp_valid, tests_open != 2'd0)
  `PMOT_ASSERT_IMPL(a_two_open_stall, tests_open == 2'd2, !req_ready)
  `PMOT_ASSERT_RST(a_rst_idle, rst, !rsp_valid && req_ready)

endmodule

bind pixel_mask_overlap_test pmot_checker u_pmot_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_type  (req.req_type),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready)
);

// ===== tb/pixel_mask_overlap_test_tb.sv =====
`timescale 1ns / 1ps
module pixel_mask_overlap_test_tb;

  localparam int RUN_LIMIT    = 2000000;
  localparam int SETTLE_TICKS = 8;
  localparam int RANDOM_WORDS = 1800;
  localparam int HOLD_TICKS   = 300;
  localparam int PRINT_CAP    = 50;

  localparam logic [pmot_pkg::REQ_W-1:0] REQ_NONE = 2'd3;

  typedef struct packed {
    logic [pmot_pkg::REQ_W-1:0]   kind;
    logic [pmot_pkg::PIX_W-1:0]   x;
    logic [pmot_pkg::PIX_W-1:0]   y;
    logic [pmot_pkg::ALPHA_W-1:0] alpha;
  } pix_word_t;

  logic clk = 1'b0;
  logic rst;

  pmot_req_if req ();
  pmot_rsp_if rsp ();
  pmot_cfg_if cfg ();

  pixel_mask_overlap_test uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  pmot_pkg::row_t                  mask_a_rows [pmot_pkg::MAX_DIM];
  pmot_pkg::row_t                  mask_b_rows [pmot_pkg::MAX_DIM];
  logic [pmot_pkg::CFG_DATA_W-1:0] box_reg [8];

  pix_word_t pending_words [$];
  bit        expected_hits [$];
  pix_word_t cur_word;
  bit        expected_bit;

  int  words_queued, words_taken;
  int  gap_left, stall_left, hold_left;
  bit  hold_done, quiet;
  int  opaque_pct, random_words;
  int  errors, results_seen, hit_count;
  int  loads_done, tests_done, cfg_writes, setups, cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_size(logic [pmot_pkg::CFG_DATA_W-1:0] v);
    int s;
    s = int'(v[pmot_pkg::SIZE_W-1:0]);
    return (s > pmot_pkg::MAX_DIM) ? pmot_pkg::MAX_DIM : s;
  endfunction

  function automatic bit scan_overlap();
    int al, ab, aw, ah, bl, bb, bw, bh;
    int x0, x1, y0, y1, sx, sy;
    al = int'($signed(box_reg[pmot_pkg::REG_A_LEFT]));
    ab = int'($signed(box_reg[pmot_pkg::REG_A_BOTTOM]));
    aw = eff_size(box_reg[pmot_pkg::REG_A_WIDTH]);
    ah = eff_size(box_reg[pmot_pkg::REG_A_HEIGHT]);
    bl = int'($signed(box_reg[pmot_pkg::REG_B_LEFT]));
    bb = int'($signed(box_reg[pmot_pkg::REG_B_BOTTOM]));
    bw = eff_size(box_reg[pmot_pkg::REG_B_WIDTH]);
    bh = eff_size(box_reg[pmot_pkg::REG_B_HEIGHT]);
    x0 = (al > bl) ? al : bl;
    x1 = (al + aw < bl + bw) ? al + aw : bl + bw;
    y0 = (ab > bb) ? ab : bb;
    y1 = (ab + ah < bb + bh) ? ab + ah : bb + bh;
    for (sy = y0; sy < y1; sy++)
      for (sx = x0; sx < x1; sx++)
        if (mask_a_rows[pmot_pkg::IDX_W'(sy - ab)][pmot_pkg::IDX_W'(sx - al)] &&
            mask_b_rows[pmot_pkg::IDX_W'(sy - bb)][pmot_pkg::IDX_W'(sx - bl)])
          return 1'b1;
    return 1'b0;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [pmot_pkg::CFG_DATA_W-1:0] rand_size();
    int r;
    logic [pmot_pkg::CFG_DATA_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) v = pmot_pkg::CFG_DATA_W'($urandom_range(1, 16));
    else if (r < 85) v = pmot_pkg::CFG_DATA_W'($urandom_range(17, pmot_pkg::MAX_DIM));
    else if (r < 92) v = pmot_pkg::CFG_DATA_W'($urandom_range(0, 31) << pmot_pkg::SIZE_W);
    else v = pmot_pkg::CFG_DATA_W'($urandom_range(pmot_pkg::MAX_DIM + 1, 127) |
                                   ($urandom_range(0, 31) << pmot_pkg::SIZE_W));
    return v;
  endfunction

  function automatic int rand_coord(logic [pmot_pkg::CFG_DATA_W-1:0] size_raw);
    int s;
    s = eff_size(size_raw);
    if (s == 0 || $urandom_range(0, 99) < 15) return $urandom_range(0, pmot_pkg::MAX_DIM - 1);
    return $urandom_range(0, s - 1);
  endfunction

  function automatic int rand_alpha();
    return ($urandom_range(0, 99) < opaque_pct) ? $urandom_range(1, 255) : 0;
  endfunction

  task automatic push_word(logic [pmot_pkg::REQ_W-1:0] kind, int x, int y, int alpha);
    pix_word_t w;
    w.kind  = kind;
    w.x     = x[pmot_pkg::PIX_W-1:0];
    w.y     = y[pmot_pkg::PIX_W-1:0];
    w.alpha = alpha[pmot_pkg::ALPHA_W-1:0];
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_reg(logic [pmot_pkg::CFG_IDX_W-1:0] idx,
                           logic [pmot_pkg::CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    box_reg[idx] = value;
    cfg_writes++;
  endtask

  task automatic settle();
    while (words_taken != words_queued || expected_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH result %0d: %s", results_seen, what);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid    <= 1'b0;
      req.req_type <= pmot_pkg::REQ_LOAD_A;
      req.pix_x    <= '0;
      req.pix_y    <= '0;
      req.alpha    <= '0;
      gap_left = 0;
    end else begin
      if (req.valid && req.ready) begin
        case (cur_word.kind)
          pmot_pkg::REQ_LOAD_A: begin
            mask_a_rows[cur_word.y][cur_word.x] = (cur_word.alpha != 0);
            loads_done++;
          end
          pmot_pkg::REQ_LOAD_B: begin
            mask_b_rows[cur_word.y][cur_word.x] = (cur_word.alpha != 0);
            loads_done++;
          end
          pmot_pkg::REQ_TEST: begin
            expected_hits.push_back(scan_overlap());
            tests_done++;
          end
          default: ;
        endcase
        words_taken++;
        gap_left = (quiet || $urandom_range(0, 1) == 0) ? 0 : rand_gap();
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          req.valid    <= 1'b1;
          req.req_type <= cur_word.kind;
          req.pix_x    <= cur_word.x;
          req.pix_y    <= cur_word.y;
          req.alpha    <= cur_word.alpha;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready generation
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (expected_hits.size() == 0) begin
          flag_mismatch($sformatf("unexpected word, hit=%b", rsp.hit));
        end else begin
          expected_bit = expected_hits.pop_front();
          if (rsp.hit !== expected_bit)
            flag_mismatch($sformatf("hit=%b, want %b", rsp.hit, expected_bit));
          if (expected_bit) hit_count++;
        end
      end
      if (setups == 4 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_TICKS;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = rand_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n, r, base_x, base_y, bx, by;
    rst          <= 1'b1;
    cfg.valid    <= 1'b0;
    cfg.index    <= pmot_pkg::REG_A_LEFT;
    cfg.data     <= '0;
    foreach (mask_a_rows[i]) begin
      mask_a_rows[i] = '0;
      mask_b_rows[i] = '0;
    end
    box_reg[pmot_pkg::REG_A_LEFT]   = '0;
    box_reg[pmot_pkg::REG_A_BOTTOM] = '0;
    box_reg[pmot_pkg::REG_A_WIDTH]  = pmot_pkg::CFG_DATA_W'(pmot_pkg::SIZE_RESET);
    box_reg[pmot_pkg::REG_A_HEIGHT] = pmot_pkg::CFG_DATA_W'(pmot_pkg::SIZE_RESET);
    box_reg[pmot_pkg::REG_B_LEFT]   = '0;
    box_reg[pmot_pkg::REG_B_BOTTOM] = '0;
    box_reg[pmot_pkg::REG_B_WIDTH]  = pmot_pkg::CFG_DATA_W'(pmot_pkg::SIZE_RESET);
    box_reg[pmot_pkg::REG_B_HEIGHT] = pmot_pkg::CFG_DATA_W'(pmot_pkg::SIZE_RESET);
    quiet        = 1'b0;
    opaque_pct   = 15;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    push_word(pmot_pkg::REQ_LOAD_A, 0, 0, 1);
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    push_word(pmot_pkg::REQ_LOAD_B, 0, 0, 255);
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    push_word(pmot_pkg::REQ_LOAD_A, 63, 63, 255);
    push_word(pmot_pkg::REQ_LOAD_B, 63, 63, 128);
    push_word(pmot_pkg::REQ_LOAD_A, 0, 0, 0);
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    push_word(REQ_NONE, 63, 63, 255);
    push_word(pmot_pkg::REQ_LOAD_B, 63, 63, 0);
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    push_word(pmot_pkg::REQ_LOAD_B, 63, 63, 1);
    settle();

    // empty box
    write_reg(pmot_pkg::REG_A_WIDTH, '0);
    cfg.valid <= 1'b0;
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    settle();

    // oversize width, boxes touching at the far edge
    write_reg(pmot_pkg::REG_A_WIDTH, 12'hFFF);
    write_reg(pmot_pkg::REG_B_LEFT, 12'd64);
    cfg.valid <= 1'b0;
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    settle();

    write_reg(pmot_pkg::REG_A_LEFT, 12'h800);
    write_reg(pmot_pkg::REG_A_BOTTOM, 12'h800);
    write_reg(pmot_pkg::REG_B_LEFT, 12'h800);
    write_reg(pmot_pkg::REG_B_BOTTOM, 12'h800);
    cfg.valid <= 1'b0;
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
    settle();

    write_reg(pmot_pkg::REG_A_LEFT, 12'h7FF);
    write_reg(pmot_pkg::REG_A_BOTTOM, 12'h7FF);
    write_reg(pmot_pkg::REG_B_LEFT, 12'h7FF);
    write_reg(pmot_pkg::REG_B_BOTTOM, 12'h7FF);
    cfg.valid <= 1'b0;
    push_word(pmot_pkg::REQ_LOAD_A, 0, 0, 7);
    push_word(pmot_pkg::REQ_LOAD_B, 0, 0, 9);
    push_word(pmot_pkg::REQ_TEST, 0, 0, 0);

    while (random_words < RANDOM_WORDS) begin
      settle();
      setups++;
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0: opaque_pct = 3;
        1: opaque_pct = 15;
        default: opaque_pct = 50;
      endcase
      r = $urandom_range(0, 9);
      base_x = (r == 0) ? -2048 : (r == 1) ? 2047 : $urandom_range(0, 4095) - 2048;
      base_y = (r == 0) ? 2047 : (r == 1) ? -2048 : $urandom_range(0, 4095) - 2048;
      if (r == 2) begin
        bx = $urandom_range(0, 4095);
        by = $urandom_range(0, 4095);
      end else begin
        bx = base_x + $urandom_range(0, 80) - 40;
        by = base_y + $urandom_range(0, 80) - 40;
      end
      write_reg(pmot_pkg::REG_A_LEFT, base_x[pmot_pkg::CFG_DATA_W-1:0]);
      write_reg(pmot_pkg::REG_A_BOTTOM, base_y[pmot_pkg::CFG_DATA_W-1:0]);
      write_reg(pmot_pkg::REG_A_WIDTH, rand_size());
      write_reg(pmot_pkg::REG_A_HEIGHT, rand_size());
      write_reg(pmot_pkg::REG_B_LEFT, bx[pmot_pkg::CFG_DATA_W-1:0]);
      write_reg(pmot_pkg::REG_B_BOTTOM, by[pmot_pkg::CFG_DATA_W-1:0]);
      write_reg(pmot_pkg::REG_B_WIDTH, rand_size());
      write_reg(pmot_pkg::REG_B_HEIGHT, rand_size());
      cfg.valid <= 1'b0;

      // hold off the result side while tests keep coming
      if (setups == 4) begin
        repeat (40) push_word(pmot_pkg::REQ_TEST, 0, 0, 0);
        random_words += 40;
      end

      n = $urandom_range(20, 100);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 42) begin
          push_word(pmot_pkg::REQ_LOAD_A, rand_coord(box_reg[pmot_pkg::REG_A_WIDTH]),
                    rand_coord(box_reg[pmot_pkg::REG_A_HEIGHT]), rand_alpha());
          random_words++;
        end else if (r < 84) begin
          push_word(pmot_pkg::REQ_LOAD_B, rand_coord(box_reg[pmot_pkg::REG_B_WIDTH]),
                    rand_coord(box_reg[pmot_pkg::REG_B_HEIGHT]), rand_alpha());
          random_words++;
        end else if (r < 97) begin
          push_word(pmot_pkg::REQ_TEST, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 255));
          random_words++;
        end else begin
          push_word(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 255));
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    $display("covered %0d pixel loads and %0d overlap tests (%0d hits) over %0d box setups",
             loads_done, tests_done, hit_count, setups);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             cfg_writes, results_seen, errors);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
